// ===== rtl/csk_pkg.sv =====
// Shared constants and types of the centrosymmetry kernel.
package csk_pkg;

  // Default sizes of the neighbor store and the shell.
  localparam int unsigned MAX_NEIGH_DEF   = 64;
  localparam int unsigned NUM_NEAREST_DEF = 12;

  // Fixed field widths.
  localparam int unsigned CoordW = 24;
  localparam int unsigned CutW   = 50;
  localparam int unsigned KeyW   = 52;
  localparam int unsigned ValW   = 55;
  localparam int unsigned SumW   = 56;
  localparam int unsigned OpW    = 26;
  localparam int unsigned PaddrW = 4;
  localparam int unsigned PdataW = 64;

  // Register index codes, taken from paddr[3].
  localparam logic CfgIdxCutoff = 1'b0;

  // Input action codes.
  localparam logic ActStart = 1'b0;
  localparam logic ActNeigh = 1'b1;

  // Sequencer states.
  typedef enum logic [3:0] {
    S_IDLE,
    S_DIST,
    S_KEEP,
    S_SEL,
    S_PA_RD,
    S_PA_LD,
    S_PB_RD,
    S_PB_LD,
    S_PM,
    S_PW,
    S_QSEL,
    S_DONE
  } state_e;

endpackage

// ===== rtl/centrosymmetry_kernel.sv =====
// Top level of the centrosymmetry kernel: sequencer, shared squarer and stores.
//
// Channel   Direction  Handshake                 Payload
// in        request    in_valid_i / in_stall_o   action_i pos_x_i pos_y_i pos_z_i last_i
// out       request    out_valid_o / out_stall_i centro_value_o full_shell_o overflow_o
// config    APB write  psel penable pwrite       paddr pwdata (prdata on read)
//
// A neighbor item goes through the squarer, one coordinate at a time, and a store write.
// A last item that leaves at least N = NumNearest neighbors kept then adds a selection
// of the N nearest through the neighbor RAM read port, the squared lengths of all
// P = N*(N-1)/2 pairs on the one squarer, a selection of the N/2 shortest pairs through
// the pair RAM read port, and a load of the result register.
// Reset is asynchronous and clears control state; the RAMs need no clearing.
// A result waiting under out_stall_i holds in its register while input is taken.
module centrosymmetry_kernel import csk_pkg::*; #(
  parameter int unsigned MaxNeigh   = MAX_NEIGH_DEF,
  parameter int unsigned NumNearest = NUM_NEAREST_DEF
) (
  input  logic                     clk_i,
  input  logic                     rst_ni,
  input  logic                     in_valid_i,
  output logic                     in_stall_o,
  input  logic                     action_i,
  input  logic signed [CoordW-1:0] pos_x_i,
  input  logic signed [CoordW-1:0] pos_y_i,
  input  logic signed [CoordW-1:0] pos_z_i,
  input  logic                     last_i,
  output logic                     out_valid_o,
  input  logic                     out_stall_i,
  output logic [ValW-1:0]          centro_value_o,
  output logic                     full_shell_o,
  output logic                     overflow_o,
  input  logic                     psel,
  input  logic                     penable,
  input  logic                     pwrite,
  input  logic [PaddrW-1:0]        paddr,
  input  logic [PdataW-1:0]        pwdata,
  output logic [PdataW-1:0]        prdata,
  output logic                     pready
);

  localparam int unsigned NPairs  = NumNearest * (NumNearest - 1) / 2;
  localparam int unsigned NHalf   = NumNearest / 2;
  localparam int unsigned NIdxW   = $clog2(MaxNeigh);
  localparam int unsigned PIdxW   = (NPairs > 1) ? $clog2(NPairs) : 1;
  localparam int unsigned SIdxW   = (NIdxW > PIdxW) ? NIdxW : PIdxW;
  localparam int unsigned CntMax  = (MaxNeigh > NumNearest) ? MaxNeigh : NumNearest;
  localparam int unsigned CntW    = $clog2(CntMax + 1);
  localparam int unsigned PCntW   = $clog2(NPairs + 1);
  localparam int unsigned ScanW   = (CntW > PCntW) ? CntW : PCntW;
  localparam int unsigned PickW   = $clog2(NumNearest + 1);
  localparam int unsigned PkIdxW  = $clog2(NumNearest);
  localparam int unsigned NWordW  = 3 * CoordW + CutW;

  // Sign extension of a coordinate to squarer width.
  function automatic logic signed [OpW-1:0] sx(input logic signed [CoordW-1:0] v);
    sx = {{(OpW - CoordW){v[CoordW-1]}}, v};
  endfunction

  state_e state_q, state_d;

  logic [CutW-1:0]          cut_q;
  logic signed [CoordW-1:0] cen_q [3];
  logic signed [CoordW-1:0] p_q [3];
  logic signed [CoordW-1:0] a_q [3];
  logic signed [CoordW-1:0] b_q [3];
  logic                     last_q;
  logic [CntW-1:0]          count_q;
  logic                     ovf_q;
  logic [1:0]               comp_q;
  logic [KeyW-1:0]          acc_q;
  logic [ScanW-1:0]         scan_q;
  logic                     pend_q;
  logic [SIdxW-1:0]         ridx_q;
  logic [PickW-1:0]         pass_q;
  logic [PickW-1:0]         pa_q, pb_q;
  logic [PCntW-1:0]         np_q;
  logic [NIdxW-1:0]         pick_q [NumNearest];
  logic [SumW-1:0]          sum_q;
  logic                     out_valid_q;
  logic [ValW-1:0]          value_q;
  logic                     full_q, oflag_q;

  logic                     accept;
  logic                     cfg_we;
  logic signed [CoordW-1:0] pin [3];
  logic signed [OpW-1:0]    op;
  logic signed [2*OpW-1:0]  prod;
  logic [KeyW-1:0]          sq;
  logic                     keep, store;
  logic [CntW-1:0]          cnt_next;
  logic [ScanW-1:0]         limit;
  logic                     scanning, issue, pass_end, commit;
  logic                     enter_sel, enter_q, out_load;
  logic [PickW-1:0]         pick_sel;
  logic                     nram_we, nram_re, pram_we;
  logic [NIdxW-1:0]         nram_raddr;
  logic [NWordW-1:0]        nram_wdata, nram_rdata;
  logic [KeyW-1:0]          pram_rdata;
  logic                     ms_found;
  logic [KeyW-1:0]          ms_key, cand_key;
  logic [SIdxW-1:0]         ms_idx;
  logic [SumW-1:0]          sum_sat_lim;

  assign pin[0] = pos_x_i;
  assign pin[1] = pos_y_i;
  assign pin[2] = pos_z_i;

  assign accept     = in_valid_i && (state_q == S_IDLE);
  assign in_stall_o = (state_q != S_IDLE);

  // Configuration port.
  assign pready = 1'b1;
  assign cfg_we = psel && penable && pwrite && (paddr[3] == CfgIdxCutoff);
  assign prdata = (paddr[3] == CfgIdxCutoff) ? {{(PdataW - CutW){1'b0}}, cut_q} : '0;

  // Shared squarer: center offset for a neighbor, pair vector for a pair.
  always_comb begin
    if (state_q == S_PM) begin
      op = sx(a_q[comp_q]) + sx(b_q[comp_q]) - (sx(cen_q[comp_q]) <<< 1);
    end else begin
      op = sx(p_q[comp_q]) - sx(cen_q[comp_q]);
    end
  end
  assign prod = op * op;
  assign sq   = prod[KeyW-1:0];

  // Cutoff test and store fill.
  assign keep     = acc_q < {{(KeyW - CutW){1'b0}}, cut_q};
  assign store    = keep && (count_q < CntW'(MaxNeigh));
  assign cnt_next = store ? count_q + 1'b1 : count_q;

  // Scan of a store for the selection passes.
  assign scanning = (state_q == S_SEL) || (state_q == S_QSEL);
  assign limit    = (state_q == S_SEL) ? ScanW'(count_q) : ScanW'(NPairs);
  assign issue    = scanning && (scan_q < limit);
  assign pass_end = scanning && (scan_q == limit) && !pend_q;
  assign commit   = pass_end;
  assign cand_key = (state_q == S_SEL) ?
                    {{(KeyW - CutW){1'b0}}, nram_rdata[NWordW-1 -: CutW]} : pram_rdata;

  // Next state.
  always_comb begin
    state_d = state_q;
    unique case (state_q)
      S_IDLE: begin
        if (accept) begin
          if (action_i == ActNeigh) begin
            state_d = S_DIST;
          end else if (last_i) begin
            state_d = S_DONE;
          end
        end
      end
      S_DIST: begin
        if (comp_q == 2'd2) state_d = S_KEEP;
      end
      S_KEEP: begin
        if (!last_q) begin
          state_d = S_IDLE;
        end else if (cnt_next >= CntW'(NumNearest)) begin
          state_d = S_SEL;
        end else begin
          state_d = S_DONE;
        end
      end
      S_SEL: begin
        if (pass_end && (pass_q == PickW'(NumNearest - 1))) state_d = S_PA_RD;
      end
      S_PA_RD: state_d = S_PA_LD;
      S_PA_LD: state_d = S_PB_RD;
      S_PB_RD: state_d = S_PB_LD;
      S_PB_LD: state_d = S_PM;
      S_PM: begin
        if (comp_q == 2'd2) state_d = S_PW;
      end
      S_PW: begin
        if (pb_q != PickW'(NumNearest - 1)) begin
          state_d = S_PB_RD;
        end else if (pa_q == PickW'(NumNearest - 2)) begin
          state_d = S_QSEL;
        end else begin
          state_d = S_PA_RD;
        end
      end
      S_QSEL: begin
        if (pass_end && (pass_q == PickW'(NHalf - 1))) state_d = S_DONE;
      end
      S_DONE: begin
        if (!out_valid_q || !out_stall_i) state_d = S_IDLE;
      end
      default: state_d = S_IDLE;
    endcase
  end

  // Memory and selection controls.
  always_comb begin
    enter_sel  = (state_q == S_KEEP) && (state_d == S_SEL);
    enter_q    = (state_q == S_PW) && (state_d == S_QSEL);
    out_load   = (state_q == S_DONE) && (!out_valid_q || !out_stall_i);
    pick_sel   = (state_q == S_PA_RD) ? pa_q : pb_q;
    nram_we    = (state_q == S_KEEP) && store;
    nram_re    = ((state_q == S_SEL) && issue) ||
                 (state_q == S_PA_RD) || (state_q == S_PB_RD);
    nram_raddr = (state_q == S_SEL) ? scan_q[NIdxW-1:0] : pick_q[pick_sel[PkIdxW-1:0]];
    nram_wdata = {acc_q[CutW-1:0], p_q[2], p_q[1], p_q[0]};
    pram_we    = (state_q == S_PW);
  end

  // Neighbor positions with their squared distances.
  csk_ram #(
    .Width (NWordW),
    .Depth (MaxNeigh)
  ) u_nram (
    .clk_i   (clk_i),
    .we_i    (nram_we),
    .waddr_i (count_q[NIdxW-1:0]),
    .wdata_i (nram_wdata),
    .re_i    (nram_re),
    .raddr_i (nram_raddr),
    .rdata_o (nram_rdata)
  );

  // Squared pair lengths.
  csk_ram #(
    .Width (KeyW),
    .Depth (NPairs)
  ) u_pram (
    .clk_i   (clk_i),
    .we_i    (pram_we),
    .waddr_i (np_q[PIdxW-1:0]),
    .wdata_i (acc_q),
    .re_i    ((state_q == S_QSEL) && issue),
    .raddr_i (scan_q[PIdxW-1:0]),
    .rdata_o (pram_rdata)
  );

  // Shared minimum search for both selections.
  csk_minscan #(
    .IdxW (SIdxW)
  ) u_minscan (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .clear_i      (enter_sel || enter_q),
    .pass_start_i (enter_sel || enter_q || commit),
    .commit_i     (commit),
    .cand_valid_i (scanning && pend_q),
    .cand_key_i   (cand_key),
    .cand_idx_i   (ridx_q),
    .found_o      (ms_found),
    .best_key_o   (ms_key),
    .best_idx_o   (ms_idx)
  );

  // Control registers.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      cut_q       <= '1;
      count_q     <= '0;
      ovf_q       <= 1'b0;
      out_valid_q <= 1'b0;
      comp_q      <= '0;
      pend_q      <= 1'b0;
      scan_q      <= '0;
      pass_q      <= '0;
      pa_q        <= '0;
      pb_q        <= '0;
      np_q        <= '0;
      for (int i = 0; i < 3; i++) cen_q[i] <= '0;
    end else begin
      state_q <= state_d;
      if (cfg_we) cut_q <= pwdata[CutW-1:0];

      // Item intake and list bookkeeping.
      if (accept) begin
        comp_q <= '0;
        if (action_i == ActStart) begin
          for (int i = 0; i < 3; i++) cen_q[i] <= pin[i];
          count_q <= '0;
          ovf_q   <= 1'b0;
        end
      end
      if (state_q == S_KEEP) begin
        count_q <= cnt_next;
        if (keep && !store) ovf_q <= 1'b1;
      end

      // Component counter of the squarer.
      if ((state_q == S_DIST) || (state_q == S_PM)) begin
        comp_q <= (comp_q == 2'd2) ? 2'd0 : comp_q + 2'd1;
      end
      if (state_q == S_PB_LD) comp_q <= '0;

      // Scan counters.
      if (enter_sel || enter_q) begin
        scan_q <= '0;
        pend_q <= 1'b0;
        pass_q <= '0;
      end else if (scanning) begin
        pend_q <= issue;
        if (issue) begin
          scan_q <= scan_q + 1'b1;
        end else if (commit) begin
          scan_q <= '0;
          pass_q <= pass_q + 1'b1;
        end
      end

      // Pair indexes.
      if (enter_sel) begin
        pa_q <= '0;
        np_q <= '0;
      end
      if (state_q == S_PA_LD) pb_q <= pa_q + 1'b1;
      if (state_q == S_PW) begin
        np_q <= np_q + 1'b1;
        if (pb_q != PickW'(NumNearest - 1)) begin
          pb_q <= pb_q + 1'b1;
        end else begin
          pa_q <= pa_q + 1'b1;
        end
      end

      // Result register and end of the atom.
      if (out_load) begin
        out_valid_q <= 1'b1;
        count_q     <= '0;
        ovf_q       <= 1'b0;
      end else if (!out_stall_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  assign sum_sat_lim = {1'b0, {ValW{1'b1}}};

  // Payload registers.
  always_ff @(posedge clk_i) begin
    if (accept && (action_i == ActNeigh)) begin
      for (int i = 0; i < 3; i++) p_q[i] <= pin[i];
      last_q <= last_i;
    end
    if (accept && (action_i == ActStart)) begin
      last_q <= last_i;
    end
    if ((state_q == S_DIST) || (state_q == S_PM)) begin
      acc_q <= ((comp_q == 2'd0) ? '0 : acc_q) + sq;
    end
    if (issue) ridx_q <= scan_q[SIdxW-1:0];
    if ((state_q == S_SEL) && commit) begin
      pick_q[pass_q[PkIdxW-1:0]] <= ms_idx[NIdxW-1:0];
    end
    if (state_q == S_PA_LD) begin
      a_q[0] <= nram_rdata[CoordW-1:0];
      a_q[1] <= nram_rdata[2*CoordW-1:CoordW];
      a_q[2] <= nram_rdata[3*CoordW-1:2*CoordW];
    end
    if (state_q == S_PB_LD) begin
      b_q[0] <= nram_rdata[CoordW-1:0];
      b_q[1] <= nram_rdata[2*CoordW-1:CoordW];
      b_q[2] <= nram_rdata[3*CoordW-1:2*CoordW];
    end
    if (enter_q) begin
      sum_q <= '0;
    end else if ((state_q == S_QSEL) && commit) begin
      sum_q <= sum_q + SumW'(ms_key);
    end
    if (out_load) begin
      full_q  <= (count_q >= CntW'(NumNearest));
      oflag_q <= ovf_q;
      if (count_q < CntW'(NumNearest)) begin
        value_q <= '0;
      end else if (sum_q > sum_sat_lim) begin
        value_q <= '1;
      end else begin
        value_q <= sum_q[ValW-1:0];
      end
    end
  end

  assign out_valid_o    = out_valid_q;
  assign centro_value_o = value_q;
  assign full_shell_o   = full_q;
  assign overflow_o     = oflag_q;

  // The neighbor count never passes the store depth.
  a_count_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    count_q <= CntW'(MaxNeigh))
    else $error("neighbor count beyond store depth");

  // A store write always lands inside the store.
  a_write_in_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    nram_we |-> (count_q < CntW'(MaxNeigh)))
    else $error("neighbor write beyond store depth");

  // Each selection pass ends with a candidate found.
  a_pass_found: assert property (@(posedge clk_i) disable iff (!rst_ni)
    commit |-> ms_found)
    else $error("selection pass ended without a candidate");

  // A result without a full shell carries a zero value.
  a_empty_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && !full_shell_o) |-> (centro_value_o == '0))
    else $error("nonzero value without a full shell");

endmodule

// ===== rtl/csk_ram.sv =====
// Generic single-write, single-read RAM with registered read data.
module csk_ram #(
  parameter int unsigned Width = 8,
  parameter int unsigned Depth = 16,
  localparam int unsigned AddrW = (Depth > 1) ? $clog2(Depth) : 1
) (
  input  logic             clk_i,
  input  logic             we_i,
  input  logic [AddrW-1:0] waddr_i,
  input  logic [Width-1:0] wdata_i,
  input  logic             re_i,
  input  logic [AddrW-1:0] raddr_i,
  output logic [Width-1:0] rdata_o
);

  logic [Width-1:0] mem_q [Depth];
  logic [Width-1:0] rdata_q;

  // Write port and registered read port.
  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

// ===== rtl/csk_minscan.sv =====
// Running minimum over a scan, restricted to keys above the previous pick.
module csk_minscan import csk_pkg::*; #(
  parameter int unsigned IdxW = 6
) (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  logic            clear_i,
  input  logic            pass_start_i,
  input  logic            commit_i,
  input  logic            cand_valid_i,
  input  logic [KeyW-1:0] cand_key_i,
  input  logic [IdxW-1:0] cand_idx_i,
  output logic            found_o,
  output logic [KeyW-1:0] best_key_o,
  output logic [IdxW-1:0] best_idx_o
);

  logic            has_prev_q;
  logic            found_q;
  logic [KeyW-1:0] prev_key_q, best_key_q;
  logic [IdxW-1:0] prev_idx_q, best_idx_q;
  logic            above;
  logic            take;

  // Keys order by value, then by index, so every key is unique.
  assign above = !has_prev_q || (cand_key_i > prev_key_q) ||
                 ((cand_key_i == prev_key_q) && (cand_idx_i > prev_idx_q));
  assign take  = cand_valid_i && above && (!found_q || (cand_key_i < best_key_q));

  // Control flags.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      has_prev_q <= 1'b0;
      found_q    <= 1'b0;
    end else begin
      if (clear_i) begin
        has_prev_q <= 1'b0;
      end else if (commit_i) begin
        has_prev_q <= 1'b1;
      end
      if (pass_start_i) begin
        found_q <= 1'b0;
      end else if (take) begin
        found_q <= 1'b1;
      end
    end
  end

  // Best and previous keys.
  always_ff @(posedge clk_i) begin
    if (take) begin
      best_key_q <= cand_key_i;
      best_idx_q <= cand_idx_i;
    end
    if (commit_i) begin
      prev_key_q <= best_key_q;
      prev_idx_q <= best_idx_q;
    end
  end

  assign found_o    = found_q;
  assign best_key_o = best_key_q;
  assign best_idx_o = best_idx_q;

endmodule

// ===== tb/tb_top.sv =====
// Testbench of the centrosymmetry kernel: directed and random atoms against a predictor.
`timescale 1ns / 1ps

// Scoreboard: holds the neighbor list per atom and the expected per-atom results.
class csp_board;
  typedef struct packed {
    logic [csk_pkg::ValW-1:0] value;
    logic                     full;
    logic                     ovf;
  } csp_result_t;

  logic signed [23:0] centre [3];
  logic signed [23:0] neigh  [64][3];
  logic [49:0]        dsq    [64];
  int                 count;
  bit                 ovf_mark;
  logic [49:0]        cutoff;
  csp_result_t        pending [$];
  int                 errors;
  int                 results_seen;

  function new();
    centre   = '{0, 0, 0};
    count    = 0;
    ovf_mark = 0;
    cutoff   = '1;
    errors   = 0;
    results_seen = 0;
  endfunction

  // Sum of the six smallest pair lengths over the twelve nearest neighbors.
  function logic [54:0] shell_value();
    int   pick [12];
    bit   used [64];
    logic [51:0] pl [66];
    bit   pused [66];
    int   best, n;
    logic [55:0] sum;
    longint d;
    logic [51:0] s;
    for (int i = 0; i < 64; i++) used[i] = 0;
    for (int a = 0; a < 12; a++) begin
      best = -1;
      for (int b = 0; b < count; b++)
        if (!used[b] && (best < 0 || dsq[b] < dsq[best])) best = b;
      used[best] = 1;
      pick[a] = best;
    end
    n = 0;
    for (int a = 0; a < 12; a++)
      for (int b = a + 1; b < 12; b++) begin
        s = 0;
        for (int c = 0; c < 3; c++) begin
          d = longint'(neigh[pick[a]][c]) + longint'(neigh[pick[b]][c])
              - 2 * longint'(centre[c]);
          s += 52'(d * d);
        end
        pl[n] = s;
        pused[n] = 0;
        n++;
      end
    sum = 0;
    for (int a = 0; a < 6; a++) begin
      best = -1;
      for (int b = 0; b < 66; b++)
        if (!pused[b] && (best < 0 || pl[b] < pl[best])) best = b;
      pused[best] = 1;
      sum += pl[best];
    end
    return (sum > 56'(55'h7FFFFFFFFFFFFF)) ? '1 : sum[54:0];
  endfunction

  // Note one accepted request.
  function void note_request(logic act, logic signed [23:0] x, logic signed [23:0] y,
                             logic signed [23:0] z, logic lst);
    logic signed [23:0] p [3];
    longint      dd;
    logic [51:0] d;
    csp_result_t r;
    p = '{x, y, z};
    if (act == csk_pkg::ActStart) begin
      centre = p;
      count = 0;
      ovf_mark = 0;
    end else begin
      d = 0;
      for (int c = 0; c < 3; c++) begin
        dd = longint'(p[c]) - longint'(centre[c]);
        d += 52'(dd * dd);
      end
      if (d < {2'b0, cutoff}) begin
        if (count < 64) begin
          neigh[count] = p;
          dsq[count] = d[49:0];
          count++;
        end else ovf_mark = 1;
      end
    end
    if (lst) begin
      r.full  = (count >= 12);
      r.value = r.full ? shell_value() : '0;
      r.ovf   = ovf_mark;
      pending.push_back(r);
      count = 0;
      ovf_mark = 0;
    end
  endfunction

  // Compare one result with the oldest expectation.
  function void check_result(logic [54:0] v, logic f, logic o);
    csp_result_t e;
    results_seen++;
    if (pending.size() == 0) begin
      $display("%0t: unexpected result value=%0d full=%0b ovf=%0b", $time, v, f, o);
      errors++;
      return;
    end
    e = pending.pop_front();
    if (e.value !== v) begin
      $display("%0t: centro_value expected %0d actual %0d", $time, e.value, v);
      errors++;
    end
    if (e.full !== f) begin
      $display("%0t: full_shell expected %0b actual %0b", $time, e.full, f);
      errors++;
    end
    if (e.ovf !== o) begin
      $display("%0t: overflow expected %0b actual %0b", $time, e.ovf, o);
      errors++;
    end
  endfunction
endclass

module tb_top;
  import csk_pkg::*;

  localparam longint CycleLimit = 3000000;

  logic clk_i = 1'b0;
  logic rst_ni = 1'b0;
  logic in_valid_i = 1'b0;
  logic in_stall_o;
  logic action_i = ActStart;
  logic signed [CoordW-1:0] pos_x_i = '0, pos_y_i = '0, pos_z_i = '0;
  logic last_i = 1'b0;
  logic out_valid_o;
  logic out_stall_i = 1'b0;
  logic [ValW-1:0] centro_value_o;
  logic full_shell_o, overflow_o;
  logic psel = 1'b0, penable = 1'b0, pwrite = 1'b0;
  logic [PaddrW-1:0] paddr = '0;
  logic [PdataW-1:0] pwdata = '0;
  logic [PdataW-1:0] prdata;
  logic pready;

  centrosymmetry_kernel DUT (.*);

  csp_board board = new();
  int  send_idle_pct = 0;
  int  stall_pct = 0;
  longint cycles = 0;
  int  requests_sent = 0;
  logic signed [23:0] cx, cy, cz;

  always begin
    #2 clk_i = 1'b1;
    #2 clk_i = 1'b0;
  end

  // Cycle count and timeout.
  always @(posedge clk_i) begin
    cycles <= cycles + 1;
    if (cycles > CycleLimit) begin
      $display("timeout after %0d cycles", cycles);
      $display("FAIL");
      $finish;
    end
  end

  // Receiver side: random stalls and result checking.
  always @(posedge clk_i) begin
    if (rst_ni) begin
      if (out_valid_o && !out_stall_i)
        board.check_result(centro_value_o, full_shell_o, overflow_o);
      out_stall_i <= ($urandom_range(99) < stall_pct);
    end
  end

  // Send one request, with random idle cycles ahead of it. Valid stays high after
  // the accepting edge until the next request or an explicit drop.
  task automatic send(logic act, logic signed [23:0] x, logic signed [23:0] y,
                      logic signed [23:0] z, logic lst);
    while ($urandom_range(99) < send_idle_pct) begin
      in_valid_i <= 1'b0;
      @(posedge clk_i);
    end
    in_valid_i <= 1'b1;
    action_i <= act;
    pos_x_i <= x;
    pos_y_i <= y;
    pos_z_i <= z;
    last_i <= lst;
    @(posedge clk_i);
    while (in_stall_o) @(posedge clk_i);
    board.note_request(act, x, y, z, lst);
    requests_sent++;
  endtask

  // Register write over the APB port, only while the block is idle.
  task automatic write_cutoff(logic [49:0] v);
    in_valid_i <= 1'b0;
    while (board.pending.size() != 0) @(posedge clk_i);
    repeat (12000) @(posedge clk_i);
    psel <= 1'b1;
    pwrite <= 1'b1;
    paddr <= {CfgIdxCutoff, 3'b000};
    pwdata <= {14'b0, v};
    @(posedge clk_i);
    penable <= 1'b1;
    @(posedge clk_i);
    psel <= 1'b0;
    penable <= 1'b0;
    pwrite <= 1'b0;
    board.cutoff = v;
  endtask

  function automatic logic signed [23:0] offset(int span);
    return 24'($signed($urandom_range(2 * span)) - span);
  endfunction

  // One atom: start, n + far_cnt neighbors near the centre or, by chance, anywhere, last on the final.
  task automatic atom(int n, int span, int far_cnt);
    int total;
    cx = 24'($urandom);
    cy = 24'($urandom);
    cz = 24'($urandom);
    send(ActStart, cx, cy, cz, 1'b0);
    total = n + far_cnt;
    for (int i = 0; i < total; i++) begin
      if (i < far_cnt || $urandom_range(3) != 0 || i >= total - 1)
        send(ActNeigh, cx + offset(span), cy + offset(span), cz + offset(span),
             i == total - 1);
      else
        send(ActNeigh, 24'($urandom), 24'($urandom), 24'($urandom), 1'b0);
    end
  endtask

  task automatic random_phase(int idle, int stall, int atoms);
    send_idle_pct = idle;
    stall_pct = stall;
    for (int a = 0; a < atoms; a++) begin
      if ($urandom_range(9) == 0)
        send(1'($urandom_range(1)), 24'($urandom), 24'($urandom), 24'($urandom),
             1'($urandom_range(1)));
      else
        atom($urandom_range(10, 18), (1 << $urandom_range(4, 14)), $urandom_range(2));
    end
  endtask

  initial begin
    repeat (11) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // Directed: extremes, start with last, too few, ties, store overflow.
    send(ActStart, 24'sh7FFFFF, 24'sh800000, 24'sh7FFFFF, 1'b1);
    send(ActStart, 24'sh800000, 24'sh800000, 24'sh800000, 1'b0);
    for (int i = 0; i < 13; i++)
      send(ActNeigh, (i % 2) ? 24'sh7FFFFF : 24'sh800000, 24'sh7FFFFF,
           (i % 3) ? 24'sh800000 : 24'sh7FFFFF, i == 12);
    send(ActStart, 24'sd0, 24'sd0, 24'sd0, 1'b0);
    send(ActNeigh, 24'sd4096, 24'sd0, 24'sd0, 1'b0);
    send(ActNeigh, 24'sd0, 24'sd0, 24'sd0, 1'b1);
    for (int i = 0; i < 14; i++)
      send(ActNeigh, (i % 2) ? 24'sd100 : -24'sd100, 24'sd0, 24'sd5, i == 13);
    send(ActNeigh, 24'sd7, 24'sd7, 24'sd7, 1'b0);
    send(ActStart, 24'sd1, 24'sd2, 24'sd3, 1'b0);
    for (int i = 0; i < 70; i++)
      send(ActNeigh, offset(3000), offset(3000), offset(3000), i == 69);

    random_phase(0, 0, 5);
    write_cutoff(50'd0);
    random_phase(84, 0, 4);
    write_cutoff(50'd1 << 24);
    random_phase(0, 84, 4);
    write_cutoff(50'd1 << 40);
    random_phase(26, 26, 4);
    write_cutoff('1);
    random_phase(0, 0, 3);

    in_valid_i <= 1'b0;
    while (board.pending.size() != 0) @(posedge clk_i);
    repeat (12000) @(posedge clk_i);
    $display("Sent %0d requests and checked %0d results over four cutoffs", requests_sent,
             board.results_seen);
    $display("and idle phases on both sides, including overflow and short shells.");
    if (board.errors == 0 && board.pending.size() == 0) begin
      $display("PASS");
    end else begin
      $display("FAIL");
    end
    $finish;
  end
endmodule
